FILE: design/fprr_pkg.sv
// Package for the fixed-point row resampler: request kinds, field widths, store sizes, and types.
// Shared by the front end, the MAC engine, and the top level.
package fprr_pkg;

    localparam int FRAC_BITS = 32 - 8 - 2;
    localparam int NCH       = 4;
    localparam int POS_W     = 10;
    localparam int COEF_W    = 24;
    localparam int CNT_W     = 7;
    localparam int PIX_W     = 8;

    // Store sizes, tied to the 10-bit positions and 6-bit tap index of the request word.
    localparam int LINE_MAX  = 1024;
    localparam int OUT_MAX   = 1024;
    localparam int MAX_TAPS  = 64;
    localparam int CA_W      = $clog2(OUT_MAX*MAX_TAPS);
    localparam int OA_W      = $clog2(OUT_MAX);
    localparam int LA_W      = $clog2(LINE_MAX);
    localparam int TC_W      = $clog2(MAX_TAPS+1);
    localparam int TI_W      = $clog2(MAX_TAPS);

    typedef enum logic [1:0] {
        REQ_COEF    = 2'd0,
        REQ_BOUNDS  = 2'd1,
        REQ_PIXEL   = 2'd2,
        REQ_COMPUTE = 2'd3
    } req_t;

    // One compute job, as it is passed from the front end to the engine.
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             in_range;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_HEAD = 2'd1,
        ST_RUN  = 2'd2,
        ST_DONE = 2'd3
    } eng_state_t;

    // Engine status that goes back to the top level.
    typedef struct packed {
        logic busy;
    } eng_stat_t;

endpackage

FILE: design/fprr_engine.sv
// MAC engine: works through one compute job per run, one tap per cycle across all channels.
// Depends on fprr_pkg. Owns the coefficient, bounds, and line memories.
module fprr_engine (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [2:0]                             channel_count,
    // Memory writes from the front end.
    input  logic                                   coef_we,
    input  logic [fprr_pkg::CA_W-1:0]              coef_addr,
    input  logic signed [fprr_pkg::COEF_W-1:0]     coef_wdata,
    input  logic                                   bnd_we,
    input  logic [fprr_pkg::OA_W-1:0]              bnd_addr,
    input  logic [fprr_pkg::POS_W-1:0]             bnd_first,
    input  logic [fprr_pkg::TC_W-1:0]              bnd_count,
    input  logic                                   pix_we,
    input  logic [fprr_pkg::LA_W-1:0]              pix_addr,
    input  logic [4*fprr_pkg::PIX_W-1:0]           pix_wdata,
    // Job queue head.
    input  logic                                   job_valid,
    input  fprr_pkg::job_t                         job,
    output logic                                   job_pop,
    // Result word.
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output logic [fprr_pkg::POS_W-1:0]             res_pos,
    output logic [4*fprr_pkg::PIX_W-1:0]           res_pix,
    output fprr_pkg::eng_stat_t                    stat
);
    import fprr_pkg::*;

    localparam int IX_W = POS_W + 1 > LA_W + 1 ? POS_W + 1 : LA_W + 1;
    localparam int ACC_W = 48;

    logic signed [COEF_W-1:0] coef_mem [OUT_MAX*MAX_TAPS];
    logic [POS_W-1:0]         first_mem [OUT_MAX];
    logic [TC_W-1:0]          count_mem [OUT_MAX];
    logic [4*PIX_W-1:0]       line_mem [LINE_MAX];

    eng_state_t state_reg, state_next;
    logic [POS_W-1:0] pos_reg;
    logic             rng_reg;
    logic [TC_W-1:0]  t_reg, t_next;
    logic [TC_W-1:0]  n_reg;
    logic [POS_W-1:0] first_reg;
    logic             mac_vld_reg;
    logic             mac_skip_reg;
    logic signed [COEF_W-1:0] coef_rd_reg;
    logic [4*PIX_W-1:0]       pix_rd_reg;
    logic [OA_W-1:0]  job_addr;
    logic [OA_W-1:0]  ra_addr;
    logic [POS_W-1:0] hd_first_reg;
    logic [TC_W-1:0]  hd_count_reg;
    logic [IX_W-1:0]  idx;
    logic             idx_ok;
    logic signed [ACC_W-1:0] acc_reg [NCH];
    logic             res_valid_reg;
    logic [4*PIX_W-1:0] res_pix_reg;
    logic             start, issue, finish;

    assign job_addr = job.pos[OA_W-1:0];
    assign ra_addr  = pos_reg[OA_W-1:0];
    assign idx      = IX_W'(first_reg) + IX_W'(t_reg);
    assign idx_ok   = idx < IX_W'(LINE_MAX);

    // Memory writes and registered reads. The bounds are read from the queue head
    // address, so they are ready in ST_HEAD right after the pop.
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_addr] <= coef_wdata;
        end
        if (bnd_we)
        begin
            first_mem[bnd_addr] <= bnd_first;
            count_mem[bnd_addr] <= bnd_count;
        end
        if (pix_we)
        begin
            line_mem[pix_addr] <= pix_wdata;
        end
        hd_first_reg <= first_mem[job_addr];
        hd_count_reg <= count_mem[job_addr];
        coef_rd_reg  <= coef_mem[CA_W'({ra_addr, t_reg[TI_W-1:0]})];
        pix_rd_reg   <= line_mem[idx[LA_W-1:0]];
    end

    // Sequencer: fetch the bounds, then issue one tap per cycle.
    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        start      = 1'b0;
        issue      = 1'b0;
        finish     = 1'b0;
        job_pop    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid && !res_valid_reg)
                begin
                    job_pop    = 1'b1;
                    start      = 1'b1;
                    t_next     = '0;
                    state_next = job.in_range ? ST_HEAD : ST_DONE;
                end
            end
            ST_HEAD:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (t_reg >= n_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    issue  = 1'b1;
                    t_next = t_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!mac_vld_reg)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mac_vld_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mac_vld_reg <= issue;
            if (finish)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Job data, tap counter, and bounds captured after the head read.
    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        mac_skip_reg <= !idx_ok;
        if (start)
        begin
            pos_reg <= job.pos;
            rng_reg <= job.in_range;
        end
        if (state_reg == ST_HEAD)
        begin
            first_reg <= hd_first_reg;
            n_reg     <= hd_count_reg;
        end
    end

    // Accumulators: one product per channel per tap.
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NCH; c++)
        begin
            if (start)
            begin
                acc_reg[c] <= ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
            end
            else if (mac_vld_reg && !mac_skip_reg)
            begin
                acc_reg[c] <= acc_reg[c] + ACC_W'($signed({1'b0,
                    pix_rd_reg[c*PIX_W +: PIX_W]}) * coef_rd_reg);
            end
        end
    end

    // Clamp and channel mask at the end of a job.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                if (!rng_reg || c >= int'(channel_count))
                begin
                    res_pix_reg[c*PIX_W +: PIX_W] <= '0;
                end
                else if (acc_reg[c] < 0)
                begin
                    res_pix_reg[c*PIX_W +: PIX_W] <= '0;
                end
                else if ((acc_reg[c] >>> FRAC_BITS) > 255)
                begin
                    res_pix_reg[c*PIX_W +: PIX_W] <= 8'd255;
                end
                else
                begin
                    res_pix_reg[c*PIX_W +: PIX_W] <= acc_reg[c][FRAC_BITS +: PIX_W];
                end
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_pos   = pos_reg;
    assign res_pix   = res_pix_reg;
    assign stat.busy = state_reg != ST_IDLE;
endmodule

FILE: design/fprr_front.sv
// Front end: accepts request words, performs loads, queues compute jobs.
// Depends on fprr_pkg.
module fprr_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          req_type,
    input  logic [fprr_pkg::POS_W-1:0]          out_pos,
    input  logic [5:0]                          tap,
    input  logic signed [fprr_pkg::COEF_W-1:0]  coef,
    input  logic [fprr_pkg::POS_W-1:0]          first_in,
    input  logic [fprr_pkg::CNT_W-1:0]          tap_count,
    input  logic [fprr_pkg::POS_W-1:0]          in_pos,
    input  logic [4*fprr_pkg::PIX_W-1:0]        pixel,
    output logic                                coef_we,
    output logic [fprr_pkg::CA_W-1:0]           coef_addr,
    output logic signed [fprr_pkg::COEF_W-1:0]  coef_wdata,
    output logic                                bnd_we,
    output logic [fprr_pkg::OA_W-1:0]           bnd_addr,
    output logic [fprr_pkg::POS_W-1:0]          bnd_first,
    output logic [fprr_pkg::TC_W-1:0]           bnd_count,
    output logic                                pix_we,
    output logic [fprr_pkg::LA_W-1:0]           pix_addr,
    output logic [4*fprr_pkg::PIX_W-1:0]        pix_wdata,
    output logic                                job_valid,
    output fprr_pkg::job_t                      job,
    input  logic                                job_pop,
    input  fprr_pkg::eng_stat_t                 stat
);
    import fprr_pkg::*;

    localparam int QD   = 2;

    job_t       q_reg [QD];
    logic [1:0] cnt_reg;
    logic [1:0] wr_idx;
    logic       acc, push, pos_ok, tap_ok;

    // Loads must not overtake queued or running jobs that read the stores.
    assign in_ready = (req_type == REQ_COMPUTE) ? (cnt_reg < 2'(QD))
                                                : (cnt_reg == '0 && !stat.busy);
    assign acc    = in_valid && in_ready;
    assign pos_ok = 32'(out_pos) < OUT_MAX;
    assign tap_ok = 32'(tap) < MAX_TAPS;

    assign coef_we    = acc && req_type == REQ_COEF && pos_ok && tap_ok;
    assign coef_addr  = {out_pos[OA_W-1:0], tap[TI_W-1:0]};
    assign coef_wdata = coef;
    assign bnd_we     = acc && req_type == REQ_BOUNDS && pos_ok;
    assign bnd_addr   = out_pos[OA_W-1:0];
    assign bnd_first  = first_in;
    assign bnd_count  = (32'(tap_count) > MAX_TAPS) ? TC_W'(MAX_TAPS) : TC_W'(tap_count);
    assign pix_we     = acc && req_type == REQ_PIXEL && 32'(in_pos) < LINE_MAX;
    assign pix_addr   = in_pos[LA_W-1:0];
    assign pix_wdata  = pixel;
    assign push       = acc && req_type == REQ_COMPUTE;

    assign job_valid = cnt_reg != '0;
    assign job       = q_reg[0];
    assign wr_idx    = cnt_reg - 2'(job_pop);

    // Two-entry job queue between front end and engine.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_reg + 2'(push) - 2'(job_pop);
        end
    end

    // A new job lands in the first free slot after any pop in the same cycle.
    always_ff @(posedge clk)
    begin
        if (push && wr_idx == 2'd0)
        begin
            q_reg[0] <= '{pos: out_pos, in_range: pos_ok};
        end
        else if (job_pop)
        begin
            q_reg[0] <= q_reg[1];
        end
        if (push && wr_idx == 2'd1)
        begin
            q_reg[1] <= '{pos: out_pos, in_range: pos_ok};
        end
    end
endmodule

FILE: design/fixed_point_resample_row.sv
// One row pass of a separable resize: load coefficient, bounds and pixel words, then
// request output positions. The stores hold 1024 output positions of up to 64 taps and
// a 1024-pixel line. A compute word is popped by the single MAC engine, which fetches its
// bounds, then does one tap per cycle for all four channels, drains, and registers the
// result. Loads wait until queued and running computes are done. Depends on fprr_pkg.
module fixed_point_resample_row (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: out_pos[9:0], tap[15:10], coef[39:16], first_in[49:40], tap_count[56:50],
    // in_pos[66:57], sample_c0..c3[98:67], zero[103:99]
    input  logic [103:0] s_axis_tdata,
    // tuser: req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: result_pos[9:0], out_c0..out_c3[41:10], zero[47:42]
    output logic [47:0] m_axis_tdata
);
    import fprr_pkg::*;

    logic [2:0] chan_reg;
    logic coef_we, bnd_we, pix_we, job_valid, job_pop;
    logic [CA_W-1:0] coef_addr;
    logic signed [COEF_W-1:0] coef_wdata;
    logic [OA_W-1:0] bnd_addr;
    logic [POS_W-1:0] bnd_first, res_pos;
    logic [TC_W-1:0] bnd_count;
    logic [LA_W-1:0] pix_addr;
    logic [31:0] pix_wdata, res_pix;
    job_t job;
    eng_stat_t stat;

    // Channel count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= 3'd4;
        end
        else if (cfg_we)
        begin
            chan_reg <= cfg_wdata;
        end
    end

    fprr_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .req_type(s_axis_tuser), .out_pos(s_axis_tdata[9:0]), .tap(s_axis_tdata[15:10]),
        .coef(s_axis_tdata[39:16]), .first_in(s_axis_tdata[49:40]),
        .tap_count(s_axis_tdata[56:50]), .in_pos(s_axis_tdata[66:57]),
        .pixel(s_axis_tdata[98:67]),
        .coef_we(coef_we), .coef_addr(coef_addr), .coef_wdata(coef_wdata),
        .bnd_we(bnd_we), .bnd_addr(bnd_addr), .bnd_first(bnd_first), .bnd_count(bnd_count),
        .pix_we(pix_we), .pix_addr(pix_addr), .pix_wdata(pix_wdata),
        .job_valid(job_valid), .job(job), .job_pop(job_pop), .stat(stat)
    );

    fprr_engine u_eng (
        .clk(clk), .rst_n(rst_n), .channel_count(chan_reg),
        .coef_we(coef_we), .coef_addr(coef_addr), .coef_wdata(coef_wdata),
        .bnd_we(bnd_we), .bnd_addr(bnd_addr), .bnd_first(bnd_first), .bnd_count(bnd_count),
        .pix_we(pix_we), .pix_addr(pix_addr), .pix_wdata(pix_wdata),
        .job_valid(job_valid), .job(job), .job_pop(job_pop),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .res_pos(res_pos), .res_pix(res_pix), .stat(stat)
    );

    assign m_axis_tdata = {6'd0, res_pix, res_pos};

    // A load word is never taken while the engine is busy.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser != REQ_COMPUTE) |-> !stat.busy)
        else $error("load accepted while engine busy");
    // A job is popped only when the queue holds one.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_valid)
        else $error("pop from empty job queue");
    // A waiting result holds its data.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule

FILE: sim/fixed_point_resample_row_tb.sv
// Self-checking bench for fixed_point_resample_row: loads coefficient, bounds and pixel
// words, requests output positions and checks every result against a resampling mirror.
// Depends on fprr_pkg and the fixed_point_resample_row RTL.
`timescale 1ns / 100ps

module fixed_point_resample_row_tb;
    import fprr_pkg::*;

    localparam int LINE_N   = 1024;
    localparam int OUT_N    = 1024;
    localparam int TAPS_N   = 64;
    localparam int WD_LIMIT = 4000;

    typedef struct {
        req_t         kind;
        logic [103:0] data;
    } word_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_wdata = 3'd0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = 2'd0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;

    fixed_point_resample_row uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 clk = ~clk;

    // Mirror of the block's stores and channel setting, updated on accepted words.
    logic signed [23:0] mir_coef [OUT_N*TAPS_N];
    logic [9:0]         mir_start [OUT_N];
    logic [6:0]         mir_count [OUT_N];
    logic [31:0]        mir_line [LINE_N];
    logic [2:0]         mir_chan = 3'd4;
    logic [47:0]        pending_results [$];

    // Generator bookkeeping: which entries the queued words will have written.
    bit          plan_coef_ok [OUT_N*TAPS_N];
    bit          plan_bounds_ok [OUT_N];
    bit          plan_pixel_ok [LINE_N];
    int          plan_start [OUT_N];
    int          plan_count [OUT_N];
    word_t       word_queue [$];

    bit          no_idle = 1'b0;
    int          errors = 0;
    int          src_gap = 0;
    int          snk_gap = 0;
    int          quiet_cycles = 0;

    // Resample one output position as the block should.
    function automatic logic [47:0] predict_resample(logic [9:0] pos);
        logic [47:0] res;
        longint      acc;
        int          first;
        int          n;
        int          idx;
        res = '0;
        res[9:0] = pos;
        first = mir_start[pos];
        n = mir_count[pos];
        for (int c = 0; c < 4; c++)
        begin
            if (c < mir_chan)
            begin
                acc = 64'sd1 <<< (FRAC_BITS - 1);
                for (int t = 0; t < n; t++)
                begin
                    idx = first + t;
                    if (idx < LINE_N)
                        acc += longint'(mir_line[idx][8*c +: 8])
                             * longint'(mir_coef[pos*TAPS_N + t]);
                end
                if (acc < 0)
                    res[10 + 8*c +: 8] = 8'd0;
                else if ((acc >>> FRAC_BITS) > 255)
                    res[10 + 8*c +: 8] = 8'd255;
                else
                    res[10 + 8*c +: 8] = 8'(acc >>> FRAC_BITS);
            end
        end
        return res;
    endfunction

    // Apply one accepted input word to the mirror.
    task automatic apply_word(logic [1:0] kind, logic [103:0] d);
        logic [9:0] pos;
        logic [6:0] n;
        pos = d[9:0];
        n = d[56:50];
        case (req_t'(kind))
            REQ_COEF:   mir_coef[pos*TAPS_N + d[15:10]] = d[39:16];
            REQ_BOUNDS:
            begin
                mir_start[pos] = d[49:40];
                mir_count[pos] = (n > TAPS_N) ? 7'(TAPS_N) : n;
            end
            REQ_PIXEL:  mir_line[d[66:57]] = d[98:67];
            REQ_COMPUTE: pending_results.push_back(predict_resample(pos));
            default: ;
        endcase
    endtask

    // Build a word: fields the request does not use carry random junk.
    function automatic word_t make_word(req_t kind, int pos, int tap, int cf, int first,
                                        int n, int ipos, logic [31:0] px);
        word_t w;
        w.kind = kind;
        w.data = 104'({$urandom, $urandom, $urandom, $urandom});
        w.data[103:99] = '0;
        w.data[9:0] = 10'(pos);
        if (kind == REQ_COEF)
        begin
            w.data[15:10] = 6'(tap);
            w.data[39:16] = 24'(cf);
            plan_coef_ok[pos*TAPS_N + tap] = 1'b1;
        end
        if (kind == REQ_BOUNDS)
        begin
            w.data[49:40] = 10'(first);
            w.data[56:50] = 7'(n);
            plan_bounds_ok[pos] = 1'b1;
            plan_start[pos] = first;
            plan_count[pos] = (n > TAPS_N) ? TAPS_N : n;
        end
        if (kind == REQ_PIXEL)
        begin
            w.data[66:57] = 10'(ipos);
            w.data[98:67] = px;
            plan_pixel_ok[ipos] = 1'b1;
        end
        return w;
    endfunction

    // True when a compute of this position reads only written entries.
    function automatic bit plan_ready(int pos);
        if (!plan_bounds_ok[pos])
            return 1'b0;
        for (int t = 0; t < plan_count[pos]; t++)
        begin
            if (!plan_coef_ok[pos*TAPS_N + t])
                return 1'b0;
            if (plan_start[pos] + t < LINE_N && !plan_pixel_ok[plan_start[pos] + t])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // Coefficients mostly sum to about one half on average, so results spread over 0..255.
    function automatic int rand_coef(int n);
        int base;
        int v;
        base = 4194304 / ((n < 1) ? 1 : n);
        case ($urandom_range(0, 11))
            0: return -8388608;
            1: return 8388607;
            2: return int'($urandom_range(0, 16777215)) - 8388608;
            default:
            begin
                v = int'($urandom_range(0, 2*base)) - base / 2;
                return (v > 8388607) ? 8388607 : v;
            end
        endcase
    endfunction

    task automatic push_compute(int pos);
        word_queue.push_back(make_word(REQ_COMPUTE, pos, 0, 0, 0, 0, 0, '0));
    endtask

    // One well-formed kernel setup with random content, then computes on it.
    task automatic add_kernel();
        int pos;
        int n;
        int first;
        int used;
        pos = $urandom_range(0, OUT_N - 1);
        case ($urandom_range(0, 15))
            0: n = $urandom_range(65, 127);
            1: n = $urandom_range(17, 64);
            2: n = 0;
            default: n = $urandom_range(1, 16);
        endcase
        used = (n > TAPS_N) ? TAPS_N : n;
        first = ($urandom_range(0, 5) == 0) ? $urandom_range(LINE_N - 8, LINE_N - 1)
                                            : $urandom_range(0, LINE_N - 1);
        word_queue.push_back(make_word(REQ_BOUNDS, pos, 0, 0, first, n, 0, '0));
        for (int t = 0; t < used; t++)
            word_queue.push_back(make_word(REQ_COEF, pos, t, rand_coef(used), 0, 0, 0, '0));
        for (int t = 0; t < used && first + t < LINE_N; t++)
            if (!plan_pixel_ok[first + t] || $urandom_range(0, 3) == 0)
                word_queue.push_back(make_word(REQ_PIXEL, 0, 0, 0, 0, 0, first + t,
                    {rand_byte(), rand_byte(), rand_byte(), rand_byte()}));
        repeat ($urandom_range(1, 3))
            push_compute(pos);
    endtask

    // Noise: stray loads, and computes on any position that is safe to read.
    task automatic add_noise();
        int pos;
        pos = $urandom_range(0, OUT_N - 1);
        case ($urandom_range(0, 4))
            0: word_queue.push_back(make_word(REQ_COEF, pos, $urandom_range(0, TAPS_N - 1),
                                              rand_coef(8), 0, 0, 0, '0));
            1: word_queue.push_back(make_word(REQ_PIXEL, 0, 0, 0, 0, 0,
                    $urandom_range(0, LINE_N - 1), {rand_byte(), rand_byte(),
                    rand_byte(), rand_byte()}));
            2: word_queue.push_back(make_word(REQ_BOUNDS, pos, 0, 0,
                    $urandom_range(0, LINE_N - 1), $urandom_range(0, 127), 0, '0));
            default:
                for (int k = 0; k < 8; k++)
                begin
                    pos = $urandom_range(0, OUT_N - 1);
                    if (plan_ready(pos))
                    begin
                        push_compute(pos);
                        break;
                    end
                end
        endcase
    endtask

    // Let queued words drain and the engine settle before touching the register.
    task automatic wait_idle();
        wait (word_queue.size() == 0 && pending_results.size() == 0 && !s_axis_tvalid);
        repeat (100) @(posedge clk);
    endtask

    // Source side: present queued words, with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        word_t w;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (src_gap > 0)
            begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                src_gap <= $urandom_range(0, 11);
                s_axis_tvalid <= 1'b0;
            end
            else if (word_queue.size() > 0)
            begin
                w = word_queue.pop_front();
                s_axis_tdata <= w.data;
                s_axis_tuser <= w.kind;
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: random stall bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (snk_gap > 0)
        begin
            snk_gap <= snk_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            snk_gap <= $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: track register writes, predict on accepted input words, check results.
    always @(posedge clk)
    begin
        logic [47:0] want;
        if (rst_n)
        begin
            if (cfg_we)
                mir_chan = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                apply_word(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result word %h", m_axis_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (want[9:0] !== m_axis_tdata[9:0]
                        || want[41:10] !== m_axis_tdata[41:10]
                        || m_axis_tdata[47:42] !== 6'd0)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch %0d/%0d exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                want[9:0], m_axis_tdata[9:0], want[17:10], want[25:18],
                                want[33:26], want[41:34], m_axis_tdata[17:10],
                                m_axis_tdata[25:18], m_axis_tdata[33:26], m_axis_tdata[41:34]);
                    end
                end
            end
            // Watchdog on cycles with no accepted word on either side.
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WD_LIMIT)
            begin
                $display("fixed_point_resample_row test failed");
                $finish;
            end
        end
    end

    // Stimulus: directed words, then random phases under several channel settings.
    initial
    begin
        int settings [6] = '{1, 0, 7, 2, 3, 4};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Zero taps: result is the rounding term only.
        word_queue.push_back(make_word(REQ_BOUNDS, 0, 0, 0, 5, 0, 0, '0));
        push_compute(0);
        // Full-scale pixel with largest coefficient saturates high; most negative clamps low.
        word_queue.push_back(make_word(REQ_PIXEL, 0, 0, 0, 0, 0, 1023, 32'hFFFF_FFFF));
        word_queue.push_back(make_word(REQ_BOUNDS, 1, 0, 0, 1023, 1, 0, '0));
        word_queue.push_back(make_word(REQ_COEF, 1, 0, 8388607, 0, 0, 0, '0));
        push_compute(1);
        word_queue.push_back(make_word(REQ_COEF, 1, 0, -8388608, 0, 0, 0, '0));
        push_compute(1);
        // Kernel that runs past the end of the line.
        word_queue.push_back(make_word(REQ_PIXEL, 0, 0, 0, 0, 0, 1022, 32'h00FF_8040));
        word_queue.push_back(make_word(REQ_BOUNDS, 1023, 0, 0, 1022, 4, 0, '0));
        for (int t = 0; t < 4; t++)
            word_queue.push_back(make_word(REQ_COEF, 1023, t, 2097152, 0, 0, 0, '0));
        push_compute(1023);
        // Largest position and tap index, with an oversized tap count; every tap is loaded.
        for (int t = 4; t < 63; t++)
            word_queue.push_back(make_word(REQ_COEF, 1023, t, rand_coef(64), 0, 0, 0, '0));
        word_queue.push_back(make_word(REQ_COEF, 1023, 63, -1, 0, 0, 0, '0));
        word_queue.push_back(make_word(REQ_PIXEL, 0, 0, 0, 0, 0, 1020, 32'h7F10_FF01));
        word_queue.push_back(make_word(REQ_PIXEL, 0, 0, 0, 0, 0, 1021, 32'h2080_C0E0));
        word_queue.push_back(make_word(REQ_BOUNDS, 1023, 0, 0, 1020, 127, 0, '0));
        push_compute(1023);

        for (int ph = 0; ph <= 6; ph++)
        begin
            if (ph > 0)
            begin
                wait_idle();
                @(posedge clk);
                cfg_we <= 1'b1;
                cfg_wdata <= 3'(settings[ph - 1]);
                @(posedge clk);
                cfg_we <= 1'b0;
            end
            if (ph == 6)
                no_idle = 1'b1;
            for (int k = 0; k < 170; )
            begin
                int size_prev;
                size_prev = word_queue.size();
                if ($urandom_range(0, 2) == 0)
                    add_noise();
                else
                    add_kernel();
                k += word_queue.size() - size_prev;
                wait (word_queue.size() < 40);
            end
        end

        wait (word_queue.size() == 0 && pending_results.size() == 0 && !s_axis_tvalid);
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("fixed_point_resample_row test passed");
        else
            $display("fixed_point_resample_row test failed");
        $finish;
    end

endmodule
